[sv/qoi_pkg.sv]
`default_nettype none

package qoi_pkg;

    // Opcode tags and fixed bytes of the stream.
    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;

    localparam int RUN_MAX     = 62;
    localparam int HASH_W      = 6;
    localparam int INDEX_DEPTH = 1 << HASH_W;
    localparam logic [HASH_W-1:0] HASH_BIAS = HASH_W'((255 * 11) % INDEX_DEPTH);

    // One pixel gives at most a run byte, four RGB bytes and the end marker.
    localparam int OP_BYTES   = 4;
    localparam int MARK_BYTES = 8;
    localparam int MAX_BYTES  = 1 + OP_BYTES + MARK_BYTES;
    localparam int LEN_W      = $clog2(MAX_BYTES + 1);
    localparam logic [MARK_BYTES*8-1:0] END_MARK = 64'h0100_0000_0000_0000;

    typedef logic [23:0] rgb_t;

    // Bytes of one pixel, first byte in the low bits.
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] data;
        logic [LEN_W-1:0]       len;
        logic                   eoi;
    } byte_pkt_t;

endpackage

`default_nettype wire

[sv/qoi_rgb_pixel_encoder.sv]
`default_nettype none

// QOI opcode encoder for RGB pixels (alpha fixed at 255), no stream header.
// Input channel: one pixel word per accepted cycle (in_valid high, in_stall
// low) carrying red, green, blue and last_pixel. Output channel: one byte
// word per accepted cycle, with last_of_item on the final byte of a pixel
// and end_of_image on the final end-marker byte.
// A pixel is registered together with its color index read, then coded in
// the next cycle and handed to the byte serializer once it is free; its
// first byte shows on the output in the cycle after that hand-over.
// The one-byte output port sets the pace: a pixel's bytes leave one per
// accepted output cycle, up to thirteen (typically one to four), and a
// pixel that only extends a run gives no byte. A new pixel is taken
// while the previous pixel's bytes are draining.
// The 64-entry color index sits in a synchronous RAM; a write to the
// entry being read in the same cycle is forwarded. Valid bits are flops,
// so reset and the last pixel clear the index at once without a clearing pass.
// When the receiver stalls, the current byte holds, the coder waits and
// in_stall rises once a pixel is waiting to be coded.
// Reset clears the previous pixel to black, the run count and the index.
module qoi_rgb_pixel_encoder (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [7:0] red,
    input  wire  [7:0] green,
    input  wire  [7:0] blue,
    input  wire        last_pixel,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_item,
    output logic       end_of_image
);
    import qoi_pkg::*;

    // Coding stage.
    logic              s2_valid_reg;
    rgb_t              s2_pix_reg;
    logic              s2_last_reg;
    logic [HASH_W-1:0] s2_hash_reg;
    rgb_t              rd_q_reg;
    logic              fwd_hit_reg;
    rgb_t              fwd_data_reg;

    // Encoder state.
    rgb_t              prev_reg;
    logic [5:0]        run_reg;
    logic [INDEX_DEPTH-1:0] valid_reg;
    rgb_t              idx_mem [INDEX_DEPTH];

    logic              in_accept;
    logic              commit;
    logic              ser_free;
    logic [HASH_W-1:0] in_hash;
    rgb_t              in_pix;
    rgb_t              entry;
    logic              same;
    logic              hit;
    logic              wr_en;
    logic [6:0]        run_inc;
    logic [5:0]        run_next;
    logic              run_emit;
    logic [7:0]        run_byte;
    logic signed [8:0] dr;
    logic signed [8:0] dg;
    logic signed [8:0] db;
    logic signed [7:0] rg;
    logic signed [7:0] bg;
    logic [31:0]       op_data;
    logic [2:0]        op_len;
    logic [(OP_BYTES+MARK_BYTES)*8-1:0] body;
    byte_pkt_t         pkt;

    assign in_pix = {red, green, blue};

    // Hash (3r + 5g + 7b + 255*11) mod 64, kept to six bits throughout.
    assign in_hash = HASH_W'({red[4:0], 1'b0}) + HASH_W'(red)
                   + HASH_W'({green[3:0], 2'b00}) + HASH_W'(green)
                   + HASH_W'({blue[3:0], 3'b000}) - HASH_W'(blue)
                   + HASH_BIAS;

    assign commit    = s2_valid_reg && ser_free;
    assign in_stall  = s2_valid_reg && !commit;
    assign in_accept = in_valid && !in_stall;

    assign entry = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
    assign same  = (s2_pix_reg == prev_reg);
    assign hit   = valid_reg[s2_hash_reg] && (entry == s2_pix_reg);
    assign wr_en = commit && !same && !hit;

    assign dr = 9'({1'b0, s2_pix_reg[23:16]}) - 9'({1'b0, prev_reg[23:16]});
    assign dg = 9'({1'b0, s2_pix_reg[15:8]}) - 9'({1'b0, prev_reg[15:8]});
    assign db = 9'({1'b0, s2_pix_reg[7:0]}) - 9'({1'b0, prev_reg[7:0]});
    assign rg = dr[7:0] - dg[7:0];
    assign bg = db[7:0] - dg[7:0];
    assign run_inc = {1'b0, run_reg} + 7'd1;

    always_comb
    begin
        run_emit = 1'b0;
        run_byte = OP_RUN;
        run_next = run_reg;
        op_data  = '0;
        op_len   = '0;
        if (same)
        begin
            if (run_inc >= 7'(RUN_MAX))
            begin
                run_emit = 1'b1;
                run_byte = OP_RUN | 8'(RUN_MAX - 1);
                run_next = '0;
            end
            else
            begin
                run_next = run_inc[5:0];
            end
        end
        else
        begin
            run_next = '0;
            if (run_reg != '0)
            begin
                run_emit = 1'b1;
                run_byte = OP_RUN | {2'b00, run_reg - 6'd1};
            end
            if (hit)
            begin
                op_data = {24'h0, OP_INDEX | {2'b00, s2_hash_reg}};
                op_len  = 3'd1;
            end
            else if (dr >= -9'sd2 && dr <= 9'sd1 && dg >= -9'sd2 && dg <= 9'sd1
                     && db >= -9'sd2 && db <= 9'sd1)
            begin
                op_data = {24'h0, OP_DIFF | {2'b00, dr[1:0] + 2'd2,
                           dg[1:0] + 2'd2, db[1:0] + 2'd2}};
                op_len  = 3'd1;
            end
            else if (dg >= -9'sd32 && dg <= 9'sd31 && rg >= -8'sd8 && rg <= 8'sd7
                     && bg >= -8'sd8 && bg <= 8'sd7)
            begin
                op_data = {16'h0, rg[3:0] + 4'd8, bg[3:0] + 4'd8,
                           OP_LUMA | {2'b00, dg[5:0] + 6'd32}};
                op_len  = 3'd2;
            end
            else
            begin
                op_data = {s2_pix_reg[7:0], s2_pix_reg[15:8], s2_pix_reg[23:16], OP_RGB};
                op_len  = 3'd4;
            end
        end
        // A run still pending at the last pixel is flushed before the marker.
        if (s2_last_reg && run_next != '0)
        begin
            run_emit = 1'b1;
            run_byte = OP_RUN | {2'b00, run_next - 6'd1};
        end
    end

    always_comb
    begin
        body = (s2_last_reg ? {32'h0, END_MARK} : '0) << {op_len, 3'b000};
        body = body | {64'h0, op_data};
        if (run_emit)
        begin
            pkt.data = {body, run_byte};
        end
        else
        begin
            pkt.data = {8'h00, body};
        end
        pkt.len = LEN_W'(run_emit) + LEN_W'(op_len)
                + (s2_last_reg ? LEN_W'(MARK_BYTES) : '0);
        pkt.eoi = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            prev_reg     <= '0;
            run_reg      <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s2_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s2_hash_reg == in_hash);
            end
            else if (commit)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                if (s2_last_reg)
                begin
                    prev_reg  <= '0;
                    run_reg   <= '0;
                    valid_reg <= '0;
                end
                else
                begin
                    prev_reg <= s2_pix_reg;
                    run_reg  <= run_next;
                    if (wr_en)
                    begin
                        valid_reg[s2_hash_reg] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_pix_reg   <= in_pix;
            s2_last_reg  <= last_pixel;
            s2_hash_reg  <= in_hash;
            rd_q_reg     <= idx_mem[in_hash];
            fwd_data_reg <= s2_pix_reg;
        end
        if (wr_en)
        begin
            idx_mem[s2_hash_reg] <= s2_pix_reg;
        end
    end

    qoi_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (commit),
        .pkt          (pkt),
        .free         (ser_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_image (end_of_image)
    );

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg < 6'(RUN_MAX))
        else $error("pending run reached the run limit without a run byte");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s2_last_reg) |=> (valid_reg == '0 && run_reg == '0 && prev_reg == '0))
        else $error("state not back at reset after the last pixel");

    a_miss_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !s2_last_reg) |=> valid_reg[$past(s2_hash_reg)])
        else $error("index entry not marked valid after a miss");

endmodule

`default_nettype wire

[sv/qoi_ser.sv]
`default_nettype none

module qoi_ser (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  wire qoi_pkg::byte_pkt_t pkt,
    output logic                 free,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [7:0]           out_byte,
    output logic                 last_of_item,
    output logic                 end_of_image
);
    import qoi_pkg::*;

    logic [MAX_BYTES*8-1:0] buf_reg;
    logic [LEN_W-1:0]       count_reg;
    logic                   eoi_reg;
    logic                   take;

    assign out_valid    = (count_reg != '0);
    assign take         = out_valid && !out_stall;
    assign free         = (count_reg == '0) || ((count_reg == LEN_W'(1)) && take);
    assign out_byte     = buf_reg[7:0];
    assign last_of_item = (count_reg == LEN_W'(1));
    assign end_of_image = (count_reg == LEN_W'(1)) && eoi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            eoi_reg   <= 1'b0;
        end
        else if (load)
        begin
            count_reg <= pkt.len;
            eoi_reg   <= pkt.eoi;
        end
        else if (take)
        begin
            count_reg <= count_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= pkt.data;
        end
        else if (take)
        begin
            buf_reg <= {8'h00, buf_reg[MAX_BYTES*8-1:8]};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(MAX_BYTES))
        else $error("byte count beyond the longest word sequence");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((count_reg == '0) || ((count_reg == LEN_W'(1)) && take)))
        else $error("serializer loaded while bytes are still pending");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(buf_reg[7:0]) && $stable(count_reg)))
        else $error("pending byte changed while stalled");

endmodule

`default_nettype wire

[tb/qoi_rgb_pixel_encoder_test.sv]
`timescale 1ns / 100ps

module qoi_rgb_pixel_encoder_test;

    import qoi_pkg::*;

    typedef struct packed {
        logic [7:0] val;
        logic       item_end;
        logic       image_end;
    } coded_byte_t;

    // Tracks the encoder state and holds the bytes still owed by the block.
    class opcode_tracker;
        rgb_t        prev_rgb;
        int          run_len;
        logic        idx_valid [INDEX_DEPTH];
        rgb_t        idx_rgb [INDEX_DEPTH];
        coded_byte_t pending_bytes [$];
        int          bad_bytes;

        function new();
            clear_state();
            bad_bytes = 0;
        endfunction

        function void clear_state();
            prev_rgb = '0;
            run_len = 0;
            for (int i = 0; i < INDEX_DEPTH; i++)
            begin
                idx_valid[i] = 1'b0;
                idx_rgb[i] = '0;
            end
        endfunction

        function void push_byte(logic [7:0] v);
            coded_byte_t cb;
            cb.val = v;
            cb.item_end = 1'b0;
            cb.image_end = 1'b0;
            pending_bytes.push_back(cb);
        endfunction

        function void note_pixel(rgb_t pix, logic last);
            int                first_new;
            int                dr;
            int                dg;
            int                db;
            logic [HASH_W-1:0] h;
            logic signed [7:0] rg;
            logic signed [7:0] bg;
            first_new = pending_bytes.size();
            if (pix == prev_rgb)
            begin
                run_len++;
                if (run_len >= RUN_MAX)
                begin
                    push_byte(OP_RUN | 8'(RUN_MAX - 1));
                    run_len = 0;
                end
            end
            else
            begin
                if (run_len > 0)
                begin
                    push_byte(OP_RUN | 8'(run_len - 1));
                    run_len = 0;
                end
                h = HASH_W'(int'(pix[23:16]) * 3 + int'(pix[15:8]) * 5 + int'(pix[7:0]) * 7
                            + int'(HASH_BIAS));
                if (idx_valid[h] && idx_rgb[h] == pix)
                    push_byte(OP_INDEX | 8'(h));
                else
                begin
                    idx_valid[h] = 1'b1;
                    idx_rgb[h] = pix;
                    // Differences are plain integers; only the luma cross terms wrap.
                    dr = int'(pix[23:16]) - int'(prev_rgb[23:16]);
                    dg = int'(pix[15:8]) - int'(prev_rgb[15:8]);
                    db = int'(pix[7:0]) - int'(prev_rgb[7:0]);
                    rg = 8'(dr - dg);
                    bg = 8'(db - dg);
                    if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1)
                        push_byte(OP_DIFF | {2'b00, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)});
                    else if (dg >= -32 && dg <= 31 && rg >= -8 && rg <= 7 && bg >= -8 && bg <= 7)
                    begin
                        push_byte(OP_LUMA | 8'(dg + 32));
                        push_byte({4'(rg + 8), 4'(bg + 8)});
                    end
                    else
                    begin
                        push_byte(OP_RGB);
                        push_byte(pix[23:16]);
                        push_byte(pix[15:8]);
                        push_byte(pix[7:0]);
                    end
                end
                prev_rgb = pix;
            end
            if (last)
            begin
                if (run_len > 0)
                    push_byte(OP_RUN | 8'(run_len - 1));
                for (int i = 0; i < MARK_BYTES; i++)
                    push_byte(END_MARK[i*8 +: 8]);
                pending_bytes[pending_bytes.size() - 1].image_end = 1'b1;
                clear_state();
            end
            if (pending_bytes.size() > first_new)
                pending_bytes[pending_bytes.size() - 1].item_end = 1'b1;
        endfunction

        task report_mismatch(string field, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s expected %02h got %02h", $time, field, want, got);
            bad_bytes++;
        endtask

        task check_byte(logic [7:0] v, logic item_end, logic image_end);
            coded_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("unexpected word, out_byte", 8'h00, v);
                return;
            end
            want = pending_bytes.pop_front();
            if (v !== want.val)
                report_mismatch("out_byte", want.val, v);
            if (item_end !== want.item_end)
                report_mismatch("last_of_item", 8'(want.item_end), 8'(item_end));
            if (image_end !== want.image_end)
                report_mismatch("end_of_image", 8'(want.image_end), 8'(image_end));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_image;

    opcode_tracker sb;
    rgb_t          gen_prev;
    rgb_t          palette [8];
    int            items_sent;
    logic          tx_idle_on;
    logic          rx_idle_on;
    logic          hold_req;
    logic          hold_done;

    // Bit 24 marks the last pixel of an image.
    logic [24:0] warmup [0:20] = '{
        {1'b0, 24'h000000}, {1'b0, 24'h000000}, {1'b0, 24'h010000}, {1'b0, 24'hFFFFFF},
        {1'b0, 24'h000000}, {1'b0, 24'h010000}, {1'b0, 24'h151413}, {1'b0, 24'h131211},
        {1'b0, 24'h141312}, {1'b0, 24'h006400}, {1'b0, 24'hFF63FF}, {1'b0, 24'hFF63FF},
        {1'b1, 24'h000000}, {1'b0, 24'h000000}, {1'b1, 24'h000000}, {1'b1, 24'h804020},
        {1'b0, 24'h0A0A0A}, {1'b0, 24'h0A0A0A}, {1'b1, 24'hC8034D}, {1'b0, 24'h00FF00},
        {1'b0, 24'hFF00FF}
    };

    qoi_rgb_pixel_encoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_image (end_of_image)
    );

    always #4 clk = ~clk;

    task automatic send_pixel(input rgb_t pix, input logic last);
        // Items 100 to 159 run with no idling; from item 200 on the receiver holds off once.
        tx_idle_on = !(items_sent >= 100 && items_sent < 160);
        rx_idle_on = tx_idle_on;
        if (items_sent >= 200)
            hold_req = 1'b1;
        while (tx_idle_on && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red <= pix[23:16];
        green <= pix[15:8];
        blue <= pix[7:0];
        last_pixel <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_pixel(pix, last);
        items_sent++;
        gen_prev = last ? '0 : pix;
        @(negedge clk);
    endtask

    // Mostly runs, small steps and reused colors, so every opcode gets exercised.
    task automatic send_image(input int len);
        int   sent;
        int   kind;
        int   reps;
        int   dr;
        int   dg;
        int   db;
        rgb_t pix;
        sent = 0;
        while (sent < len)
        begin
            kind = $urandom_range(99);
            reps = 1;
            pix = gen_prev;
            if (kind < 25)
                reps = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 6);
            else if (kind < 40)
                pix = {8'(gen_prev[23:16] + $urandom_range(3) - 2),
                       8'(gen_prev[15:8] + $urandom_range(3) - 2),
                       8'(gen_prev[7:0] + $urandom_range(3) - 2)};
            else if (kind < 58)
            begin
                dg = int'($urandom_range(63)) - 32;
                dr = dg + int'($urandom_range(15)) - 8;
                db = dg + int'($urandom_range(15)) - 8;
                pix = {8'(int'(gen_prev[23:16]) + dr), 8'(int'(gen_prev[15:8]) + dg),
                       8'(int'(gen_prev[7:0]) + db)};
            end
            else if (kind < 72)
                pix = palette[$urandom_range(7)];
            else if (kind < 80)
                pix = {8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
                       8'($urandom_range(1) * 255)};
            else
                pix = 24'($urandom);
            if (kind >= 25 && (kind < 58 || kind >= 72))
                palette[$urandom_range(7)] = pix;
            for (int i = 0; i < reps && sent < len; i++)
            begin
                send_pixel(pix, sent == len - 1);
                sent++;
            end
        end
    endtask

    // Receiver side: random stall, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
            end
            out_stall <= rx_idle_on && ($urandom_range(99) < 16);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_byte(out_byte, last_of_item, end_of_image);
    end

    initial
    begin
        #3_200_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int len;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        red = 8'h00;
        green = 8'h00;
        blue = 8'h00;
        last_pixel = 1'b0;
        out_stall = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req = 1'b0;
        hold_done = 1'b0;
        items_sent = 0;
        gen_prev = '0;
        for (int i = 0; i < 8; i++)
            palette[i] = 24'($urandom);
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (warmup[i])
            send_pixel(warmup[i][23:0], warmup[i][24]);

        // A run long enough to force a full run word before anything else.
        for (int i = 0; i < 66; i++)
            send_pixel(gen_prev, 1'b0);

        while (items_sent < 270)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(10, 80);
            if (len > 270 - items_sent)
                len = 270 - items_sent;
            send_image(len);
        end
        in_valid <= 1'b0;

        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.bad_bytes == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
